FILE: rtl/core/rgo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgo_pkg
// Shared constants and types for the radial glow orb pixel unit.
// ----------------------------------------------------------------------------
package rgo_pkg;

    // sprite square edge, pixels
    localparam int unsigned ORB_SIZE   = 180;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned CFG_W      = 9;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned WORD_W     = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE  = 1'b1;
    localparam logic [CFG_W-1:0]     UNIT_MAX  = 9'd256;

    // geometry
    localparam int unsigned SQ_W       = 18;   // one squared doubled offset
    localparam int unsigned SUM_W      = 19;
    localparam int unsigned RAD_SHIFT  = 14;
    localparam int unsigned RAD_W      = 34;   // even, 17 digit pairs
    localparam int unsigned SQRT_STEPS = 17;
    localparam int unsigned D_W        = 17;   // Q9.8 distance
    localparam int unsigned DEN_W      = 14;
    localparam int unsigned BIG_R_W    = 15;

    localparam int unsigned CORE_BASE  = 5120; // 20.0 in Q8.8
    localparam int unsigned CORE_STEP  = 12;
    localparam int unsigned SPAN_BASE  = 8704; // 34.0 in Q8.8
    localparam int unsigned SPAN_STEP  = 22;
    localparam int unsigned EDGE_LO    = 384;  // 1.5
    localparam int unsigned EDGE_W     = 576;  // 1.5 + 0.75

    // Q0.16 fractions, one extra bit so 1.0 fits
    localparam int unsigned Q_W        = 16;
    localparam int unsigned F_W        = 17;
    localparam logic [F_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [17:0]    THREE_Q16 = 18'h30000;
    localparam logic [15:0]    HALO_GAIN = 16'd36045;

    // (x << 16) / 576 == (x * INV9_Q13) >> 13 for x < 576
    localparam int unsigned    EDGE_OFS_W = 10;
    localparam logic [19:0]    INV9_Q13   = 20'd932068;

    localparam int unsigned DIV_LANES = 2;
    localparam int unsigned LANE_HALO = 0;
    localparam int unsigned LANE_TC   = 1;

    localparam int unsigned NCH = 3;
    localparam logic [F_W-1:0] COL_IN   [NCH] = '{17'd65536, 17'd56361, 17'd51118};
    localparam logic [F_W-1:0] COL_RIM  [NCH] = '{17'd55706, 17'd27525, 17'd17039};
    localparam logic [F_W-1:0] COL_GLOW [NCH] = '{17'd57672, 17'd31457, 17'd20316};

    typedef struct packed {
        logic [EDGE_OFS_W-1:0] edge_ofs;  // distance past the inner edge
        logic                  t_zero;    // inside inner edge
        logic                  t_sat;     // at or beyond outer edge
        logic                  halo_en;   // strictly between core and halo radii
        logic                  tc_sat;    // at or beyond core radius
    } t_side;

    function automatic logic [CFG_W-1:0] sat_unit(input logic [CFG_W-1:0] v);
        return (v > UNIT_MAX) ? UNIT_MAX : v;
    endfunction

endpackage

FILE: rtl/core/rgo_pix_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgo_pix_in_if
// Pixel coordinate channel, valid/ready.
// ----------------------------------------------------------------------------
interface rgo_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] column;
    logic [7:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

FILE: rtl/core/rgo_pix_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgo_pix_out_if
// Premultiplied BGRA pixel channel, valid/ready.
// ----------------------------------------------------------------------------
interface rgo_pix_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

FILE: rtl/core/rgo_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgo_sqrt_pipe
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rgo_sqrt_pipe import rgo_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [RAD_W-1:0] i_rad,
    output logic             o_valid,
    output logic [D_W-1:0]   o_root
);

    localparam int unsigned REM_W = D_W + 3;

    logic [SQRT_STEPS-1:0] r_v;
    logic [RAD_W-1:0]      r_rad [SQRT_STEPS];
    logic [REM_W-1:0]      r_rem [SQRT_STEPS];
    logic [D_W-1:0]        r_q   [SQRT_STEPS];

    logic [RAD_W-1:0]      p_rad [SQRT_STEPS];
    logic [REM_W-1:0]      p_rem [SQRT_STEPS];
    logic [D_W-1:0]        p_q   [SQRT_STEPS];

    logic [RAD_W-1:0]      n_rad [SQRT_STEPS];
    logic [REM_W-1:0]      n_rem [SQRT_STEPS];
    logic [D_W-1:0]        n_q   [SQRT_STEPS];

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_link
        if (s == 0) begin : g_first
            assign p_rad[s] = i_rad;
            assign p_rem[s] = '0;
            assign p_q[s]   = '0;
        end else begin : g_next
            assign p_rad[s] = r_rad[s-1];
            assign p_rem[s] = r_rem[s-1];
            assign p_q[s]   = r_q[s-1];
        end
    end

    always_comb begin
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        for (int s = 0; s < SQRT_STEPS; s++) begin
            rem_sh   = {p_rem[s][REM_W-3:0], p_rad[s][RAD_W-1 -: 2]};
            trial    = {1'b0, p_q[s], 2'b01};
            n_rad[s] = {p_rad[s][RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem[s] = rem_sh - trial;
                n_q[s]   = {p_q[s][D_W-2:0], 1'b1};
            end else begin
                n_rem[s] = rem_sh;
                n_q[s]   = {p_q[s][D_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[SQRT_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= n_rad;
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_valid = r_v[SQRT_STEPS-1];
    assign o_root  = r_q[SQRT_STEPS-1];

endmodule

FILE: rtl/core/rgo_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgo_div_pipe
// Two-lane pipelined fraction divider: (num << 16) / den with num < den,
// one quotient bit per stage. Sideband flags travel alongside.
// ----------------------------------------------------------------------------
module rgo_div_pipe import rgo_pkg::*; (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [DIV_LANES-1:0][DEN_W-1:0]   i_num,
    input  logic [DIV_LANES-1:0][DEN_W-1:0]   i_den,
    input  t_side                             i_side,
    output logic                              o_valid,
    output logic [DIV_LANES-1:0][Q_W-1:0]     o_quo,
    output t_side                             o_side
);

    logic [Q_W-1:0]                    r_v;
    logic [DIV_LANES-1:0][DEN_W-1:0]   r_rem  [Q_W];
    logic [DIV_LANES-1:0][DEN_W-1:0]   r_den  [Q_W];
    logic [DIV_LANES-1:0][Q_W-1:0]     r_q    [Q_W];
    t_side                             r_side [Q_W];

    logic [DIV_LANES-1:0][DEN_W-1:0]   p_rem  [Q_W];
    logic [DIV_LANES-1:0][DEN_W-1:0]   p_den  [Q_W];
    logic [DIV_LANES-1:0][Q_W-1:0]     p_q    [Q_W];
    t_side                             p_side [Q_W];

    logic [DIV_LANES-1:0][DEN_W-1:0]   n_rem  [Q_W];
    logic [DIV_LANES-1:0][Q_W-1:0]     n_q    [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_link
        if (s == 0) begin : g_first
            assign p_rem[s]  = i_num;
            assign p_den[s]  = i_den;
            assign p_q[s]    = '0;
            assign p_side[s] = i_side;
        end else begin : g_next
            assign p_rem[s]  = r_rem[s-1];
            assign p_den[s]  = r_den[s-1];
            assign p_q[s]    = r_q[s-1];
            assign p_side[s] = r_side[s-1];
        end
    end

    always_comb begin
        logic [DEN_W:0] rem_sh;
        logic [DEN_W:0] den_x;
        logic [DEN_W:0] diff;
        for (int s = 0; s < Q_W; s++) begin
            for (int l = 0; l < DIV_LANES; l++) begin
                rem_sh = {p_rem[s][l], 1'b0};
                den_x  = {1'b0, p_den[s][l]};
                diff   = rem_sh - den_x;
                if (rem_sh >= den_x) begin
                    n_rem[s][l] = diff[DEN_W-1:0];
                    n_q[s][l]   = {p_q[s][l][Q_W-2:0], 1'b1};
                end else begin
                    n_rem[s][l] = rem_sh[DEN_W-1:0];
                    n_q[s][l]   = {p_q[s][l][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Q_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_den  <= p_den;
            r_q    <= n_q;
            r_side <= p_side;
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quo   = r_q[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

FILE: rtl/core/rgo_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgo_shade
// Eight-stage shading pipe: smoothstep core, cubic halo, alpha, colour
// blend, fade and byte packing. Last stage is the output register.
// ----------------------------------------------------------------------------
module rgo_shade import rgo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [Q_W-1:0]    i_frac,
    input  logic [Q_W-1:0]    i_tcq,
    input  logic [CFG_W-1:0]  i_fade,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_word
);

    localparam int unsigned STAGES = 8;

    logic [STAGES-1:0] r_v;

    // stage 1
    logic [F_W-1:0] r1_t, r1_u, r1_tc;
    logic           r1_halo_en;
    // stage 2
    logic [F_W-1:0] r2_t, r2_t2, r2_u, r2_uu, r2_tc;
    logic           r2_halo_en;
    // stage 3
    logic [F_W-1:0] r3_core, r3_u3, r3_tc;
    logic           r3_halo_en;
    // stage 4
    logic [F_W-1:0] r4_core, r4_halo;
    logic [F_W-1:0] r4_c0 [NCH];
    // stage 5
    logic [F_W-1:0] r5_a;
    logic           r5_zero;
    logic [F_W-1:0] r5_c [NCH];
    // stage 6
    logic [F_W-1:0] r6_af;
    logic           r6_zero;
    logic [F_W-1:0] r6_c [NCH];
    // stage 7
    logic [7:0]     r7_alpha;
    logic           r7_zero;
    logic [33:0]    r7_p [NCH];
    // stage 8
    logic [WORD_W-1:0] r8_word;

    logic [F_W-1:0] n1_t, n1_u, n1_tc;
    logic [F_W-1:0] n2_t2, n2_uu;
    logic [F_W-1:0] n3_core, n3_u3;
    logic [F_W-1:0] n4_halo;
    logic [F_W-1:0] n4_c0 [NCH];
    logic [F_W-1:0] n5_a;
    logic           n5_zero;
    logic [F_W-1:0] n5_c [NCH];
    logic [F_W-1:0] n6_af;
    logic [7:0]     n7_alpha;
    logic [33:0]    n7_p [NCH];
    logic [WORD_W-1:0] n8_word;

    // stage 1: edge ramp and halo coordinate
    always_comb begin
        logic [29:0] tp;
        tp = i_side.edge_ofs * INV9_Q13;
        if (i_side.t_sat) begin
            n1_t = ONE_Q16;
        end else if (i_side.t_zero) begin
            n1_t = '0;
        end else begin
            n1_t = {1'b0, tp[28:13]};
        end
        n1_u  = ONE_Q16 - {1'b0, i_frac};
        n1_tc = i_side.tc_sat ? ONE_Q16 : {1'b0, i_tcq};
    end

    // stage 2: squares
    always_comb begin
        logic [33:0] tt;
        logic [33:0] uu;
        tt    = r1_t * r1_t;
        uu    = r1_u * r1_u;
        n2_t2 = tt[32:16];
        n2_uu = uu[32:16];
    end

    // stage 3: smoothstep and cube
    always_comb begin
        logic [17:0] w3;
        logic [34:0] sp;
        logic [18:0] s;
        logic [33:0] u3p;
        w3 = THREE_Q16 - {r2_t, 1'b0};
        sp = r2_t2 * w3;
        s  = sp[34:16];
        if (s > {2'b00, ONE_Q16}) begin
            n3_core = '0;
        end else begin
            n3_core = ONE_Q16 - s[F_W-1:0];
        end
        u3p   = r2_uu * r2_u;
        n3_u3 = u3p[32:16];
    end

    // stage 4: halo gain, centre to rim colour
    always_comb begin
        logic [32:0] hg;
        logic [33:0] cp;
        hg      = HALO_GAIN * r3_u3;
        n4_halo = r3_halo_en ? hg[32:16] : '0;
        for (int k = 0; k < NCH; k++) begin
            // in*(1-tc) + rim*tc, folded into one product with a ceiling
            cp       = 34'(COL_IN[k] - COL_RIM[k]) * r3_tc + 34'd65535;
            n4_c0[k] = COL_IN[k] - 17'(cp >> 16);
        end
    end

    // stage 5: alpha, blend toward glow colour by (1 - core)
    always_comb begin
        logic [32:0]        hp;
        logic [17:0]        a_raw;
        logic signed [17:0] cdel;
        logic signed [35:0] cprod;
        logic signed [19:0] csum;
        hp    = (ONE_Q16 - r4_core) * r4_halo;
        a_raw = {1'b0, r4_core} + {1'b0, hp[32:16]};
        n5_a  = (a_raw > {1'b0, ONE_Q16}) ? ONE_Q16 : a_raw[F_W-1:0];
        n5_zero = (a_raw == '0);
        for (int k = 0; k < NCH; k++) begin
            cdel  = $signed({1'b0, r4_c0[k]}) - $signed({1'b0, COL_GLOW[k]});
            cprod = cdel * $signed({1'b0, r4_core});
            csum  = $signed({3'b000, COL_GLOW[k]}) + $signed(cprod[35:16]);
            if (csum > $signed({3'b000, ONE_Q16})) begin
                n5_c[k] = ONE_Q16;
            end else begin
                n5_c[k] = csum[F_W-1:0];
            end
        end
    end

    // stage 6: fade
    always_comb begin
        logic [25:0] ap;
        ap    = r5_a * i_fade;
        n6_af = ap[24:8];
    end

    // stage 7: alpha byte, colour times alpha
    always_comb begin
        logic [24:0] al;
        al       = ({r6_af, 8'b0} - {8'b0, r6_af}) + 25'd32768;
        n7_alpha = al[23:16];
        for (int k = 0; k < NCH; k++) begin
            n7_p[k] = r6_c[k] * r6_af;
        end
    end

    // stage 8: colour bytes and packing
    always_comb begin
        logic [41:0] chp;
        logic [7:0]  ch [NCH];
        for (int k = 0; k < NCH; k++) begin
            chp   = ({r7_p[k], 8'b0} - {8'b0, r7_p[k]}) + 42'h0_8000_0000;
            ch[k] = (chp[41:40] != 2'b00) ? 8'hFF : chp[39:32];
        end
        n8_word = r7_zero ? '0 : {r7_alpha, ch[0], ch[1], ch[2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t       <= n1_t;
            r1_u       <= n1_u;
            r1_tc      <= n1_tc;
            r1_halo_en <= i_side.halo_en;

            r2_t       <= r1_t;
            r2_t2      <= n2_t2;
            r2_u       <= r1_u;
            r2_uu      <= n2_uu;
            r2_tc      <= r1_tc;
            r2_halo_en <= r1_halo_en;

            r3_core    <= n3_core;
            r3_u3      <= n3_u3;
            r3_tc      <= r2_tc;
            r3_halo_en <= r2_halo_en;

            r4_core    <= r3_core;
            r4_halo    <= n4_halo;
            r4_c0      <= n4_c0;

            r5_a       <= n5_a;
            r5_zero    <= n5_zero;
            r5_c       <= n5_c;

            r6_af      <= n6_af;
            r6_zero    <= r5_zero;
            r6_c       <= r5_c;

            r7_alpha   <= n7_alpha;
            r7_zero    <= r6_zero;
            r7_p       <= n7_p;

            r8_word    <= n8_word;
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_word  = r8_word;

endmodule

FILE: rtl/core/radial_glow_orb_pixel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_glow_orb_pixel_unit
// Pulsing glow sprite: pixel coordinate in, premultiplied BGRA word out.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix carries one (column, row) transaction per pixel; o_pix returns
//   one pixel_word (A 31..24, R 23..16, G 15..8, B 7..0) per transaction,
//   in order. Both are valid/ready channels.
//   The config port writes loudness_level (index 0) and opacity_fade
//   (index 1); values above 256 saturate. Write only while the pipe is empty.
//   From input transaction to output valid the pipe has two front stages,
//   17 square root stages (one root bit each), one radius compare stage,
//   16 divider stages (one quotient bit each) and eight shading stages.
//   Throughput is one pixel per cycle while the output is not stalled.
//   The whole pipe advances together; when the receiver holds off ready with
//   a result waiting, every stage holds and i_pix.ready drops in the same
//   cycle, so nothing is lost or repeated.
//   Reset (synchronous, active low) empties the pipe and sets loudness to 0
//   and fade to 256.
// ----------------------------------------------------------------------------
module radial_glow_orb_pixel_unit import rgo_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rgo_pix_in_if.sink           i_pix,
    rgo_pix_out_if.source        o_pix,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic w_en;

    logic [CFG_W-1:0]   r_level;
    logic [CFG_W-1:0]   r_fade;
    logic [DEN_W-1:0]   r_core_r;
    logic [DEN_W-1:0]   r_span;
    logic [DEN_W-1:0]   r_edge_lo;
    logic [BIG_R_W-1:0] r_big_r;

    logic               r_v1, r_v2, r_vg;
    logic [PIX_W-1:0]   r_col, r_row;
    logic [SQ_W-1:0]    r_sqx, r_sqy;

    logic [RAD_W-1:0]   w_rad;
    logic [SUM_W-1:0]   w_sum;
    logic               w_sqrt_v;
    logic [D_W-1:0]     w_d;

    logic [SQ_W-1:0]    n_sqx, n_sqy;
    t_side                             n_side, r_side;
    logic [DIV_LANES-1:0][DEN_W-1:0]   n_num, r_num, r_den;
    logic                              w_div_v;
    logic [DIV_LANES-1:0][Q_W-1:0]     w_quo;
    t_side                             w_div_side;

    logic               w_out_v;
    logic [WORD_W-1:0]  w_word;

    // the whole pipe moves unless a result is waiting and not taken
    assign w_en        = !w_out_v || o_pix.ready;
    assign i_pix.ready = w_en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_fade  <= UNIT_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEVEL: r_level <= sat_unit(i_cfg_data);
                CFG_FADE:  r_fade  <= sat_unit(i_cfg_data);
                default: ;
            endcase
        end
    end

    // radii follow the level register in the next cycle
    always_ff @(posedge i_clk) begin
        r_core_r  <= DEN_W'(CORE_BASE + CORE_STEP * r_level);
        r_span    <= DEN_W'(SPAN_BASE + SPAN_STEP * r_level);
        r_edge_lo <= DEN_W'(CORE_BASE - EDGE_LO + CORE_STEP * r_level);
        r_big_r   <= BIG_R_W'(CORE_BASE + SPAN_BASE + (CORE_STEP + SPAN_STEP) * r_level);
    end

    // doubled offsets from the centre and their squares
    always_comb begin
        logic signed [10:0] hx, hy;
        logic signed [21:0] px, py;
        hx    = $signed({2'b00, r_col, 1'b1}) - $signed(11'(ORB_SIZE));
        hy    = $signed({2'b00, r_row, 1'b1}) - $signed(11'(ORB_SIZE));
        px    = hx * hx;
        py    = hy * hy;
        n_sqx = px[SQ_W-1:0];
        n_sqy = py[SQ_W-1:0];
    end

    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_rad = {1'b0, w_sum, {RAD_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vg <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_pix.valid;
            r_v2 <= r_v1;
            r_vg <= w_sqrt_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_col  <= i_pix.column;
            r_row  <= i_pix.row;
            r_sqx  <= n_sqx;
            r_sqy  <= n_sqy;
            r_side <= n_side;
            r_num  <= n_num;
            r_den[LANE_HALO] <= r_span;
            r_den[LANE_TC]   <= r_core_r;
        end
    end

    rgo_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v2),
        .i_rad   (w_rad),
        .o_valid (w_sqrt_v),
        .o_root  (w_d)
    );

    // distance against the core edge, core radius and halo radius
    always_comb begin
        logic [D_W-1:0] ofs;
        logic [D_W-1:0] dr;
        ofs = w_d - D_W'(r_edge_lo);
        dr  = w_d - D_W'(r_core_r);
        n_side.t_zero   = (w_d <= D_W'(r_edge_lo));
        n_side.t_sat    = !n_side.t_zero && (ofs >= D_W'(EDGE_W));
        n_side.edge_ofs = ofs[EDGE_OFS_W-1:0];
        n_side.halo_en  = (w_d > D_W'(r_core_r)) && (w_d < D_W'(r_big_r));
        n_side.tc_sat   = (w_d >= D_W'(r_core_r));
        n_num[LANE_HALO] = n_side.halo_en ? dr[DEN_W-1:0] : '0;
        n_num[LANE_TC]   = n_side.tc_sat ? '0 : w_d[DEN_W-1:0];
    end

    rgo_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vg),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_side),
        .o_valid (w_div_v),
        .o_quo   (w_quo),
        .o_side  (w_div_side)
    );

    rgo_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_v),
        .i_side  (w_div_side),
        .i_frac  (w_quo[LANE_HALO]),
        .i_tcq   (w_quo[LANE_TC]),
        .i_fade  (r_fade),
        .o_valid (w_out_v),
        .o_word  (w_word)
    );

    assign o_pix.valid      = w_out_v;
    assign o_pix.pixel_word = w_word;

endmodule

FILE: rtl/core/rgo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgo_checker
// Port-level checks for the glow orb pixel unit, bound to the top level.
// ----------------------------------------------------------------------------
module rgo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a waiting transaction is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("output transaction changed while stalled");

    // input side only stalls while a result waits untaken
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // premultiplied: no colour byte exceeds alpha
    a_premul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_word[23:16] <= i_out_word[31:24])
                     && (i_out_word[15:8] <= i_out_word[31:24])
                     && (i_out_word[7:0] <= i_out_word[31:24]))
        else $error("colour byte above alpha");

endmodule

bind radial_glow_orb_pixel_unit rgo_checker u_rgo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_word  (o_pix.pixel_word)
);

FILE: dv/radial_glow_orb_pixel_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_glow_orb_pixel_unit_tb
// Drives pixel coordinates through the glow orb unit under several loudness
// and fade settings and checks every returned BGRA word against a predictor.
// ----------------------------------------------------------------------------

class orb_scoreboard;
    logic [31:0] pending_words[$];
    int          n_errors;
    logic [8:0]  level;
    logic [8:0]  fade;

    function new();
        n_errors = 0;
        level    = 9'd0;
        fade     = 9'd256;
    endfunction

    static function logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function logic [31:0] shade_pixel(input logic [7:0] col, input logic [7:0] rw);
        longint      hx, hy;
        logic [63:0] lev, fd, d, r, span, big_r, lo, t, t2, s, core, halo;
        logic [63:0] frac, u, u3, a, tc, m, af, c, ch, word;
        logic [63:0] c_in[3], c_rim[3], c_glow[3];
        c_in   = '{65536, 56361, 51118};
        c_rim  = '{55706, 27525, 17039};
        c_glow = '{57672, 31457, 20316};
        lev = (level > 256) ? 256 : level;
        fd  = (fade > 256) ? 256 : fade;
        hx  = 2 * longint'(col) + 1 - 180;
        hy  = 2 * longint'(rw) + 1 - 180;
        d   = isqrt(64'(hx * hx + hy * hy) << 14);
        r     = 5120 + 12 * lev;
        span  = 8704 + 22 * lev;
        big_r = r + span;
        lo    = r - 384;
        if (d <= lo) t = 0;
        else if (d - lo >= 576) t = 65536;
        else t = ((d - lo) << 16) / 576;
        t2 = (t * t) >> 16;
        s  = (t2 * (3 * 65536 - 2 * t)) >> 16;
        if (s > 65536) s = 65536;
        core = 65536 - s;
        halo = 0;
        if (d > r && d < big_r) begin
            frac = ((d - r) << 16) / span;
            u    = 65536 - frac;
            u3   = (((u * u) >> 16) * u) >> 16;
            halo = (36045 * u3) >> 16;
        end
        a = core + (((65536 - core) * halo) >> 16);
        if (a > 65536) a = 65536;
        if (a == 0) return 32'd0;
        tc   = (d >= r) ? 65536 : (d << 16) / r;
        m    = 65536 - core;
        af   = (a * fd) >> 8;
        word = ((af * 255 + 32768) >> 16) << 24;
        for (int k = 0; k < 3; k++) begin
            c = (c_in[k] * (65536 - tc) + c_rim[k] * tc) >> 16;
            if (core < 65536) c = (c * core + c_glow[k] * m) >> 16;
            if (c > 65536) c = 65536;
            ch = (c * af * 255 + (64'd1 << 31)) >> 32;
            if (ch > 255) ch = 255;
            word = word | (ch << (16 - 8 * k));
        end
        return word[31:0];
    endfunction

    function void note_pixel(input logic [7:0] col, input logic [7:0] rw);
        pending_words = {pending_words, shade_pixel(col, rw)};
    endfunction

    function void check_word(input logic [31:0] got);
        logic [31:0] exp_w;
        if (pending_words.size() == 0) begin
            $error("pixel_word: nothing expected, actual %h", got);
            n_errors++;
            return;
        end
        exp_w = pending_words.pop_front();
        if (got !== exp_w) begin
            $error("pixel_word: expected %h actual %h", exp_w, got);
            n_errors++;
        end
    endfunction
endclass

module radial_glow_orb_pixel_unit_tb;
    import rgo_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    int   send_idle_pct;
    int   recv_idle_pct;

    rgo_pix_in_if  pix_in ();
    rgo_pix_out_if pix_out ();

    orb_scoreboard sb = new();

    radial_glow_orb_pixel_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_in.sink),
        .o_pix      (pix_out.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // receiver: random stalls, result checked at each transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_out.valid && pix_out.ready) sb.check_word(pix_out.pixel_word);
            pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end else begin
            pix_out.ready <= 1'b0;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LEVEL) sb.level = val;
        else sb.fade = val;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // valid stays high across back-to-back transactions
    task automatic send_pixel(input logic [7:0] col, input logic [7:0] rw);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid  <= 1'b1;
        pix_in.column <= col;
        pix_in.row    <= rw;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        sb.note_pixel(col, rw);
    endtask

    task automatic end_burst();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_pixels(input int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(9);
            // mostly inside the sprite, near the centre where the core and halo live
            if (pick < 6) send_pixel(8'($urandom_range(90 + 60, 90 - 60)),
                                     8'($urandom_range(150, 30)));
            else if (pick < 9) send_pixel(8'($urandom_range(179)), 8'($urandom_range(179)));
            else send_pixel(8'($urandom), 8'($urandom));
            if (i == n / 2) begin
                // hold off until the pipe has emptied
                end_burst();
                while (sb.pending_words.size() != 0) @(posedge i_clk);
            end
        end
        end_burst();
    endtask

    initial begin
        logic [8:0] lvls[6];
        logic [8:0] fds[6];
        pix_in.valid  = 1'b0;
        pix_in.column = '0;
        pix_in.row    = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_LEVEL;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        lvls = '{9'd0, 9'd256, 9'd511, 9'd128, 9'd300, 9'd37};
        fds  = '{9'd256, 9'd0, 9'd511, 9'd100, 9'd1, 9'd200};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: centre, corners, edges, beyond the square
        send_pixel(8'd89, 8'd89);
        send_pixel(8'd90, 8'd90);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd179, 8'd0);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd90, 8'd70);
        send_pixel(8'd90, 8'd68);
        send_pixel(8'd90, 8'd112);
        send_pixel(8'd110, 8'd90);
        send_pixel(8'd130, 8'd90);
        send_pixel(8'd170, 8'd170);
        send_pixel(8'd85, 8'd170);
        send_pixel(8'd170, 8'd85);
        end_burst();
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_LEVEL, lvls[ph]);
            write_reg(CFG_FADE, fds[ph]);
            if (ph < 2) begin
                send_idle_pct = 25;
                recv_idle_pct = 87;
            end else if (ph < 4) begin
                send_idle_pct = 87;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_pixel(8'd90, 8'd90);
            send_pixel(8'd0, 8'd0);
            random_pixels(70);
            drain();
        end

        if (sb.n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: radial_glow_orb_pixel_unit.f
rtl/core/rgo_pkg.sv
rtl/core/rgo_pix_in_if.sv
rtl/core/rgo_pix_out_if.sv
rtl/core/rgo_sqrt_pipe.sv
rtl/core/rgo_div_pipe.sv
rtl/core/rgo_shade.sv
rtl/core/radial_glow_orb_pixel_unit.sv
rtl/core/rgo_checker.sv
dv/radial_glow_orb_pixel_unit_tb.sv
